>>> hw/rtl/knap_pkg.sv
// Shared types and constants for the 0/1 knapsack row unit.
// No dependencies; compile first.
package knap_pkg;

  // Field widths fixed by the item and result formats
  localparam int WEIGHT_W = 16;
  localparam int VALUE_W  = 24;
  localparam int CAP_W    = 10;
  localparam int BEST_W   = 40;
  // Widest row index the unit can be built for (up to 65536 entries)
  localparam int IDX_W    = 16;

  // Issue slot of the sweep: one row entry per cycle
  typedef struct packed {
    logic             valid;
    logic             incl;   // object fits at this entry
    logic [IDX_W-1:0] idx;
  } knap_iss_t;

  // Write request from the sweep datapath to the row memory
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } knap_wr_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic busy;     // entries still in flight
    logic sat_hit;  // an include sum was clamped this cycle
  } knap_stat_t;

endpackage

>>> hw/rtl/knap_ifs.sv
// Handshake channels of the knapsack row unit: item in, result out, config write.
// Depends on knap_pkg for the field widths.
interface knap_item_if;
  import knap_pkg::*;
  logic                valid;
  logic                ready;
  logic [WEIGHT_W-1:0] item_weight;
  logic [VALUE_W-1:0]  item_value;
  logic                last_item;

  modport source (output valid, item_weight, item_value, last_item, input ready);
  modport sink   (input valid, item_weight, item_value, last_item, output ready);
endinterface

interface knap_res_if;
  import knap_pkg::*;
  logic              valid;
  logic              ready;
  logic [BEST_W-1:0] best_value;
  logic              saturated;

  modport source (output valid, best_value, saturated, input ready);
  modport sink   (input valid, best_value, saturated, output ready);
endinterface

interface knap_cfg_if;
  import knap_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

>>> hw/rtl/knap_row_mem.sv
// Row memory of best values: two registered read ports, one write port.
// No package dependency.
module knap_row_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 40
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
  input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
  output logic [WIDTH-1:0]         rd_a_data,
  output logic [WIDTH-1:0]         rd_b_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read two; read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
    end
  end

endmodule

>>> hw/rtl/knap_sweep_dp.sv
// Sweep datapath: include sum with clamp, then compare against the old entry.
// Depends on knap_pkg; fed by the row memory read data.
module knap_sweep_dp #(
  parameter int ENTRY_BITS = 40,
  parameter int AW         = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  knap_pkg::knap_iss_t      iss,
  input  logic [knap_pkg::VALUE_W-1:0] item_value,
  input  logic [ENTRY_BITS-1:0]    rd_a_data,
  input  logic [ENTRY_BITS-1:0]    rd_b_data,
  output knap_pkg::knap_wr_t       wr,
  output logic [ENTRY_BITS-1:0]    wr_data,
  output knap_pkg::knap_stat_t     stat
);
  import knap_pkg::*;

  logic                  s1_v_r, s1_incl_r;
  logic [AW-1:0]         s1_idx_r;
  logic                  s2_v_r;
  logic [AW-1:0]         s2_idx_r;
  logic [ENTRY_BITS-1:0] s2_old_r, s2_sum_r;
  logic [ENTRY_BITS:0]   sum_ext;
  logic                  carry;
  logic [ENTRY_BITS-1:0] sum_clamp;

  // Add the object's value to the entry one weight below; clamp on overflow
  always_comb begin
    sum_ext   = {1'b0, rd_b_data} + (ENTRY_BITS+1)'(item_value);
    carry     = sum_ext[ENTRY_BITS];
    sum_clamp = carry ? '1 : sum_ext[ENTRY_BITS-1:0];
  end

  // Advance the control of both stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= iss.valid;
      s2_v_r <= s1_v_r & s1_incl_r;
    end
  end

  // Hold the payload alongside
  always_ff @(posedge clk) begin
    s1_incl_r <= iss.incl;
    s1_idx_r  <= iss.idx[AW-1:0];
    s2_idx_r  <= s1_idx_r;
    s2_old_r  <= rd_a_data;
    s2_sum_r  <= sum_clamp;
  end

  // Write back only where including the object improves the entry
  assign wr.en        = s2_v_r && (s2_sum_r > s2_old_r);
  assign wr.addr      = IDX_W'(s2_idx_r);
  assign wr_data      = s2_sum_r;
  assign stat.busy    = s1_v_r | s2_v_r;
  assign stat.sat_hit = s1_v_r & s1_incl_r & carry;

endmodule

>>> hw/rtl/knapsack_01_dp_row_unit.sv
// 0/1 knapsack solver over one row of best values held in a synchronous memory.
// Each item (one object) sweeps entries CAP_MAX down to 1, one per cycle, through
// a read-modify-write path on the row memory; an item occupies the unit for that
// single sweep plus the two-stage write-back drain.
// An item marked last then has the result read out of the row (waiting while the result
// register is still held) and a clearing pass that zeroes entries CAP_MAX down to 0;
// the same clearing pass runs after reset. No item is taken during a sweep or a clearing
// pass; configuration writes are taken at any time.
// Depends on knap_pkg, knap_ifs, knap_row_mem and knap_sweep_dp.
module knapsack_01_dp_row_unit #(
  parameter int CAP_MAX    = 1023,
  parameter int ENTRY_BITS = 40
) (
  input  logic         clk,
  input  logic         rst_n,
  knap_item_if.sink    in_if,
  knap_res_if.source   out_if,
  knap_cfg_if.sink     cfg_if
);
  import knap_pkg::*;

  localparam int DEPTH = CAP_MAX + 1;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SWEEP  = 6'b000010,
    ST_DRAIN  = 6'b000100,
    ST_RES_RD = 6'b001000,
    ST_RES_LD = 6'b010000,
    ST_CLEAR  = 6'b100000
  } knap_state_t;

  knap_state_t         state_r, state_nxt;
  logic [AW-1:0]       j_r, j_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic [WEIGHT_W-1:0] w_r;
  logic [VALUE_W-1:0]  v_r;
  logic                last_r;
  logic [CAP_W-1:0]    cap_r;
  logic                sat_seen_r, sat_seen_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [BEST_W-1:0]   out_best_r;
  logic                out_sat_r;

  logic                  in_acc, out_load;
  logic [WEIGHT_W:0]     j_ext, w_ext, diff;
  logic [AW-1:0]         sel;
  knap_iss_t             iss;
  knap_wr_t              dp_wr;
  knap_stat_t            stat;
  logic [ENTRY_BITS-1:0] dp_wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_a_addr, rd_b_addr;
  logic [ENTRY_BITS-1:0] rd_a_data, rd_b_data;
  logic                  mem_wr_en;
  logic [AW-1:0]         mem_wr_addr;
  logic [ENTRY_BITS-1:0] mem_wr_data;

  assign in_if.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_if.valid & in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign out_load     = (state_r == ST_RES_LD) && (!out_valid_r || out_if.ready);

  // Issue one entry per sweep cycle; the object fits where weight <= index
  always_comb begin
    j_ext     = (WEIGHT_W+1)'(j_r);
    w_ext     = (WEIGHT_W+1)'(w_r);
    diff      = j_ext - w_ext;
    iss.valid = (state_r == ST_SWEEP);
    iss.incl  = (w_ext <= j_ext);
    iss.idx   = IDX_W'(j_r);
  end

  // Reported index saturates at the top of the row
  always_comb begin
    if (32'(cap_r) > 32'(CAP_MAX)) begin
      sel = AW'(CAP_MAX);
    end else begin
      sel = AW'(cap_r);
    end
  end

  // Steer memory reads and the single write port
  always_comb begin
    rd_en     = (state_r == ST_SWEEP) || (state_r == ST_RES_RD);
    rd_a_addr = (state_r == ST_RES_RD) ? sel : j_r;
    rd_b_addr = iss.incl ? diff[AW-1:0] : j_r;
    if (state_r == ST_CLEAR) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_r;
      mem_wr_data = '0;
    end else begin
      mem_wr_en   = dp_wr.en;
      mem_wr_addr = dp_wr.addr[AW-1:0];
      mem_wr_data = dp_wr_data;
    end
  end

  knap_row_mem #(
    .DEPTH (DEPTH),
    .WIDTH (ENTRY_BITS)
  ) u_mem (
    .clk       (clk),
    .rd_en     (rd_en),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data),
    .wr_en     (mem_wr_en),
    .wr_addr   (mem_wr_addr),
    .wr_data   (mem_wr_data)
  );

  knap_sweep_dp #(
    .ENTRY_BITS (ENTRY_BITS),
    .AW         (AW)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .iss        (iss),
    .item_value (v_r),
    .rd_a_data  (rd_a_data),
    .rd_b_data  (rd_b_data),
    .wr         (dp_wr),
    .wr_data    (dp_wr_data),
    .stat       (stat)
  );

  // Sequence sweep, drain, result read-out and clearing pass
  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SWEEP;
          j_nxt     = AW'(CAP_MAX);
        end
      end
      ST_SWEEP: begin
        if (j_r == AW'(1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          j_nxt = j_r - AW'(1);
        end
      end
      ST_DRAIN: begin
        if (!stat.busy) begin
          state_nxt = last_r ? ST_RES_RD : ST_IDLE;
        end
      end
      ST_RES_RD: begin
        state_nxt = ST_RES_LD;
      end
      ST_RES_LD: begin
        if (out_load) begin
          state_nxt = ST_CLEAR;
          clr_nxt   = AW'(CAP_MAX);
        end
      end
      ST_CLEAR: begin
        if (clr_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r - AW'(1);
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        clr_nxt   = AW'(CAP_MAX);
      end
    endcase
  end

  // Track saturation over the problem and hold the result register
  always_comb begin
    sat_seen_nxt  = sat_seen_r;
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      sat_seen_nxt = 1'b0;
    end else if (stat.sat_hit) begin
      sat_seen_nxt = 1'b1;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= AW'(CAP_MAX);
      j_r         <= '0;
      cap_r       <= '0;
      sat_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      j_r         <= j_nxt;
      sat_seen_r  <= sat_seen_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        cap_r <= cfg_if.capacity;
      end
    end
  end

  // Capture the item and the result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      w_r    <= in_if.item_weight;
      v_r    <= in_if.item_value;
      last_r <= in_if.last_item;
    end
    if (out_load) begin
      out_best_r <= BEST_W'(rd_a_data);
      out_sat_r  <= sat_seen_r;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.best_value = out_best_r;
  assign out_if.saturated  = out_sat_r;

`ifndef SYNTHESIS
  // A new item never enters while write-backs of the last one are in flight
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !stat.busy)
    else $error("item accepted with sweep write-back pending");

  // Sweep write-backs never collide with the clearing pass
  a_no_wr_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !dp_wr.en)
    else $error("sweep write during clearing pass");

  // A write-back always lands above the entry being read, so no forwarding is needed
  a_wr_above_read: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_wr.en && iss.valid) |-> (dp_wr.addr[AW-1:0] > j_r))
    else $error("write-back overlaps a pending read");

  // The result is loaded only right after its read was issued or held
  a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> ($past(state_r) == ST_RES_RD || $past(state_r) == ST_RES_LD))
    else $error("result loaded without a row read");
`endif

endmodule

>>> verif/knap_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the knapsack row unit: folds every accepted object into its own
// copy of the row of best values and compares each result item with its prediction.
// Depends on knap_pkg and the channel interfaces in knap_ifs.
module knap_result_checker #(
  parameter int CAP_MAX    = 1023,
  parameter int ENTRY_BITS = 40
) (
  input  logic  clk,
  input  logic  rst_n,
  knap_item_if  item_ch,
  knap_res_if   res_ch,
  knap_cfg_if   cfg_ch,
  output int    fail_count,
  output int    pending
);
  import knap_pkg::*;

  localparam logic [ENTRY_BITS:0] ENTRY_MAX = {1'b0, {ENTRY_BITS{1'b1}}};
  localparam int                  REPORT_MAX = 10;

  typedef struct {
    logic [BEST_W-1:0] best_value;
    logic              saturated;
  } knap_result_t;

  logic [ENTRY_BITS-1:0] row_model [0:CAP_MAX];
  logic                  sat_model;
  logic [CAP_W-1:0]      cap_model;
  knap_result_t          best_q [$];
  int                    mismatches = 0;

  // Sweep the row from the top entry down so each object counts at most once
  function automatic void fold_object(input logic [WEIGHT_W-1:0] w,
                                      input logic [VALUE_W-1:0]  v,
                                      input logic                last);
    logic [ENTRY_BITS:0] sum;
    knap_result_t        res;
    int                  sel;
    for (int j = CAP_MAX; j >= 1; j--) begin
      if (int'(w) <= j) begin
        sum = {1'b0, row_model[j - int'(w)]};
        sum = sum + v;
        // clamp the include sum; the flag sticks even if excluding wins
        if (sum > ENTRY_MAX) begin
          sum       = ENTRY_MAX;
          sat_model = 1'b1;
        end
        if (sum[ENTRY_BITS-1:0] > row_model[j]) row_model[j] = sum[ENTRY_BITS-1:0];
      end
    end
    if (last) begin
      sel = (int'(cap_model) > CAP_MAX) ? CAP_MAX : int'(cap_model);
      res.best_value = BEST_W'(row_model[sel]);
      res.saturated  = sat_model;
      best_q.push_back(res);
      // start the next problem from an empty row
      foreach (row_model[k]) row_model[k] = '0;
      sat_model = 1'b0;
    end
  endfunction

  // Track capacity writes and objects, compare result items in order
  always @(posedge clk) begin : watch
    knap_result_t want;
    if (!rst_n) begin
      foreach (row_model[k]) row_model[k] = '0;
      sat_model = 1'b0;
      cap_model = '0;
      best_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) cap_model = cfg_ch.capacity;
      if (item_ch.valid && item_ch.ready)
        fold_object(item_ch.item_weight, item_ch.item_value, item_ch.last_item);
      if (res_ch.valid && res_ch.ready) begin
        if (best_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected result item: best_value %h saturated %b",
                     res_ch.best_value, res_ch.saturated);
        end else begin
          want = best_q.pop_front();
          if (want.best_value !== res_ch.best_value || want.saturated !== res_ch.saturated) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("result mismatch: expected best_value %h saturated %b, got %h %b",
                       want.best_value, want.saturated, res_ch.best_value, res_ch.saturated);
          end
        end
      end
    end
    fail_count <= mismatches;
    pending    <= best_q.size();
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Top of the knapsack row unit testbench: clock, reset, capacity writes, object stimulus,
// random idling on both channels and the verdict.
// Depends on knap_pkg, knap_ifs, knapsack_01_dp_row_unit and knap_result_checker.
module testbench;
  import knap_pkg::*;

  localparam int CAP_MAX     = 1023;
  localparam int ENTRY_BITS  = 40;
  // one sweep, result read-out and clearing pass, with margin
  localparam int SETTLE      = 2 * CAP_MAX + 64;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 71;

  logic             clk = 1'b0;
  logic             rst_n;
  int               cycles = 0;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int               fail_count;
  int               pending;
  logic [CAP_W-1:0] cur_cap = '0;

  knap_item_if item_ch();
  knap_res_if  res_ch();
  knap_cfg_if  cfg_ch();

  knapsack_01_dp_row_unit #(.CAP_MAX(CAP_MAX), .ENTRY_BITS(ENTRY_BITS)) dut (
    .clk(clk), .rst_n(rst_n), .in_if(item_ch), .out_if(res_ch), .cfg_if(cfg_ch)
  );

  knap_result_checker #(.CAP_MAX(CAP_MAX), .ENTRY_BITS(ENTRY_BITS)) u_check (
    .clk(clk), .rst_n(rst_n), .item_ch(item_ch), .res_ch(res_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  // Stall the result channel at random
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Offer one object after a random gap and hold it until taken
  task automatic send_object(input logic [WEIGHT_W-1:0] w, input logic [VALUE_W-1:0] v,
                             input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.item_weight <= w;
    item_ch.item_value  <= v;
    item_ch.last_item   <= last;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  // Mostly weights that fit a few times over, some zero, heavy or fully random
  task automatic send_random_object();
    logic [WEIGHT_W-1:0] w;
    logic [VALUE_W-1:0]  v;
    int                  pick;
    pick = $urandom_range(9);
    if (pick == 0) w = '0;
    else if (pick == 1) w = $urandom_range(1) ? '1 : WEIGHT_W'($urandom);
    else w = WEIGHT_W'($urandom_range(1, cur_cap / 3 + 2));
    pick = $urandom_range(9);
    if (pick == 0) v = '0;
    else if (pick == 1) v = '1;
    else v = VALUE_W'($urandom);
    send_object(w, v, $urandom_range(5) == 0);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.capacity <= c;
    cur_cap = c;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Drain every result, then let a sweep or clearing pass finish
  task automatic settle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    item_ch.valid       <= 1'b0;
    item_ch.item_weight <= '0;
    item_ch.item_value  <= '0;
    item_ch.last_item   <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.capacity     <= '0;
    rst_n               <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // zero capacity reports a best value of zero whatever the objects
    write_capacity('0);
    send_object(16'd0, '1, 1'b0);
    send_object(16'd1, 24'd5, 1'b1);
    settle();

    // lone object at full weight, then one too heavy for any capacity
    write_capacity(10'd1023);
    send_object(16'd1023, '1, 1'b1);
    send_object('1, 24'd123, 1'b1);
    // weightless objects lift every entry but entry 0
    send_object(16'd1024, 24'd7, 1'b0);
    send_object(16'd0, 24'd0, 1'b0);
    send_object(16'd0, '1, 1'b1);
    send_object(16'd512, 24'hAAAAAA, 1'b0);
    send_object(16'd511, 24'h555555, 1'b0);
    send_object(16'd1, 24'd1, 1'b1);
    // textbook problem with the capacity changed before the last object
    send_object(16'd10, 24'd60, 1'b0);
    send_object(16'd20, 24'd100, 1'b0);
    settle();
    write_capacity(10'd50);
    send_object(16'd30, 24'd120, 1'b1);
    settle();

    // the same object is never taken twice
    write_capacity(10'd1);
    send_object(16'd1, 24'd9, 1'b0);
    send_object(16'd1, 24'd4, 1'b1);
    settle();

    // random phases over the idling patterns and a spread of capacities
    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct  = (p % 4 == 1) ? 79 : (p % 4 == 3) ? 20 : 0;
      recv_stall_pct = (p % 4 == 2) ? 79 : (p % 4 == 3) ? 20 : 0;
      unique case (p)
        0, 5:    write_capacity(10'd1023);
        2:       write_capacity(10'd1);
        4:       write_capacity(CAP_W'($urandom_range(2, 31)));
        6:       write_capacity('0);
        default: write_capacity(CAP_W'($urandom_range(1023)));
      endcase
      repeat (PHASE_ITEMS) send_random_object();
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
